FILE: hw/rtl/gsl_pkg.sv
// Shared types, codes and sizes for the gesture sequence lock.
// Used by the channel interfaces and every module of the block.
`default_nettype none

package gsl_pkg;

  // Table and counter sizes
  localparam int SEQ_LEN    = 8;
  localparam int TICK_WIDTH = 16;
  localparam int GOAL_SLOTS = 8;
  localparam int POS_W      = $clog2(SEQ_LEN + 1);

  // Field widths
  localparam int KIND_W  = 2;
  localparam int CODE_W  = 4;
  localparam int DRIVE_W = 2;
  localparam int COUNT_W = 4;
  localparam int CFG_W   = 32;
  localparam int TIME_W  = 16;
  localparam int ADDR_W  = 3;

  // Input word kinds
  localparam logic [KIND_W-1:0] KIND_GESTURE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd2;

  // Servo drive codes
  localparam logic [DRIVE_W-1:0] DRIVE_OFF    = 2'd0;
  localparam logic [DRIVE_W-1:0] DRIVE_LOCK   = 2'd1;
  localparam logic [DRIVE_W-1:0] DRIVE_UNLOCK = 2'd2;

  // Configuration register indexes
  localparam logic [ADDR_W-1:0] REG_GOAL      = 3'd0;
  localparam logic [ADDR_W-1:0] REG_OVERWRITE = 3'd1;
  localparam logic [ADDR_W-1:0] REG_IDLE      = 3'd2;
  localparam logic [ADDR_W-1:0] REG_DELAY     = 3'd3;
  localparam logic [ADDR_W-1:0] REG_SERVO     = 3'd4;

  // Configuration reset values
  localparam logic [CFG_W-1:0]  GOAL_RST      = 32'd0;
  localparam logic [TIME_W-1:0] OVERWRITE_RST = 16'd500;
  localparam logic [TIME_W-1:0] IDLE_RST      = 16'd5000;
  localparam logic [TIME_W-1:0] DELAY_RST     = 16'd1000;
  localparam logic [TIME_W-1:0] SERVO_RST     = 16'd1000;

  localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

  typedef struct packed {
    logic                 locked;
    logic [DRIVE_W-1:0]   servo_drive;
    logic                 toggle_pending;
    logic [COUNT_W-1:0]   collected_count;
    logic                 match_now;
  } gsl_result_t;

  // Codes outside 1..13 count as none
  function automatic logic [CODE_W-1:0] map_code(input logic [CODE_W-1:0] c);
    return (c >= 4'd1 && c <= 4'd13) ? c : 4'd0;
  endfunction

  // Clip a timing register into the counter range
  function automatic logic [TICK_WIDTH-1:0] load_count(input logic [TIME_W-1:0] v);
    if (v == '0) return TICK_WIDTH'(1);
    if (32'(v) > 32'(TICK_MAX)) return TICK_MAX;
    return TICK_WIDTH'(v);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gsl_in_if.sv
// Input channel of the gesture sequence lock: valid, ready and one input word.
// Depends on gsl_pkg for field widths.
`default_nettype none

interface gsl_in_if import gsl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CODE_W-1:0] gesture_code;

  modport source(output valid, kind, gesture_code, input ready);
  modport sink(input valid, kind, gesture_code, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gsl_out_if.sv
// Result channel of the gesture sequence lock: valid, ready and one result word.
// Depends on gsl_pkg for field widths.
`default_nettype none

interface gsl_out_if import gsl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               locked;
  logic [DRIVE_W-1:0] servo_drive;
  logic               toggle_pending;
  logic [COUNT_W-1:0] collected_count;
  logic               match_now;

  modport source(output valid, locked, servo_drive, toggle_pending, collected_count,
                 match_now, input ready);
  modport sink(input valid, locked, servo_drive, toggle_pending, collected_count,
               match_now, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gesture_sequence_lock.sv
// Gesture sequence lock, top level.
// Depends on gsl_pkg, gsl_in_if, gsl_out_if, gsl_core and gsl_out_buf.
//
// Usage:
//   gesture_in carries one word per handshake: kind (gesture, tick or toggle
//   request) and gesture_code. result_out returns exactly one word for every
//   accepted input word, in order: lock state, servo drive, toggle pending,
//   collected count and the match flag of that step.
//   The config port writes one register per cycle with cfg_wr_en high; write
//   it only while no result is outstanding.
// Update and rate:
//   The whole update of one word is done in the cycle it is accepted; its
//   result goes into the output register, or into the skid stage while the
//   output waits. A word is accepted per cycle while the skid stage is empty.
// Stall:
//   A two-entry output buffer (output register and skid stage) keeps taking
//   words while one result waits; gesture_in.ready drops only when both hold
//   a word and resumes the cycle after the receiver takes one.
// Reset:
//   rst is synchronous, active high; it clears the table, counters, lock
//   state and buffer and returns the registers to their reset values.
`default_nettype none

module gesture_sequence_lock import gsl_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wr_data,
  gsl_in_if.sink                 gesture_in,
  gsl_out_if.source              result_out
);

  logic        accept;
  logic        can_push;
  gsl_result_t step_result;

  // Take a word whenever the skid stage is empty
  assign gesture_in.ready = can_push;
  assign accept           = gesture_in.valid && can_push;

  gsl_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .step        (accept),
    .kind        (gesture_in.kind),
    .gesture_code(gesture_in.gesture_code),
    .result      (step_result)
  );

  gsl_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_result),
    .can_push  (can_push),
    .result_out(result_out)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/gsl_core.sv
// State, configuration and per-word update logic of the gesture sequence lock.
// Depends on gsl_pkg; produces the result word of each accepted input word.
`default_nettype none

module gsl_core import gsl_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wr_data,
  input  wire logic              step,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [CODE_W-1:0] gesture_code,
  output gsl_result_t            result
);

  // Configuration registers
  logic [CFG_W-1:0]  goal_sequence;
  logic [TIME_W-1:0] overwrite_ticks;
  logic [TIME_W-1:0] idle_reset_ticks;
  logic [TIME_W-1:0] toggle_delay_ticks;
  logic [TIME_W-1:0] servo_on_ticks;

  // Lock state
  logic [CODE_W-1:0]     entries [SEQ_LEN];
  logic [POS_W-1:0]      write_position;
  logic [CODE_W-1:0]     pending_gesture;
  logic [TICK_WIDTH-1:0] window_counter;
  logic [TICK_WIDTH-1:0] idle_counter;
  logic [TICK_WIDTH-1:0] delay_counter;
  logic [TICK_WIDTH-1:0] servo_counter;
  logic                  lock_state;
  logic                  scheduled_flag;
  logic [DRIVE_W-1:0]    drive_mode;

  logic [CODE_W-1:0]     entries_next [SEQ_LEN];
  logic [POS_W-1:0]      write_position_next;
  logic [CODE_W-1:0]     pending_gesture_next;
  logic [TICK_WIDTH-1:0] window_counter_next;
  logic [TICK_WIDTH-1:0] idle_counter_next;
  logic [TICK_WIDTH-1:0] delay_counter_next;
  logic [TICK_WIDTH-1:0] servo_counter_next;
  logic                  lock_state_next;
  logic                  scheduled_flag_next;
  logic [DRIVE_W-1:0]    drive_mode_next;
  logic                  matched;
  logic                  table_equal;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_sequence      <= GOAL_RST;
      overwrite_ticks    <= OVERWRITE_RST;
      idle_reset_ticks   <= IDLE_RST;
      toggle_delay_ticks <= DELAY_RST;
      servo_on_ticks     <= SERVO_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_GOAL:      goal_sequence      <= cfg_wr_data;
        REG_OVERWRITE: overwrite_ticks    <= cfg_wr_data[TIME_W-1:0];
        REG_IDLE:      idle_reset_ticks   <= cfg_wr_data[TIME_W-1:0];
        REG_DELAY:     toggle_delay_ticks <= cfg_wr_data[TIME_W-1:0];
        REG_SERVO:     servo_on_ticks     <= cfg_wr_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Work out the state after one input word
  always_comb begin
    logic servo_x;
    logic idle_x;
    logic win_x;
    logic delay_x;
    logic [CODE_W-1:0] goal_code;

    entries_next         = entries;
    write_position_next  = write_position;
    pending_gesture_next = pending_gesture;
    window_counter_next  = window_counter;
    idle_counter_next    = idle_counter;
    delay_counter_next   = delay_counter;
    servo_counter_next   = servo_counter;
    lock_state_next      = lock_state;
    scheduled_flag_next  = scheduled_flag;
    drive_mode_next      = drive_mode;
    matched              = 1'b0;
    table_equal          = 1'b0;
    servo_x              = 1'b0;
    idle_x               = 1'b0;
    win_x                = 1'b0;
    delay_x              = 1'b0;
    goal_code            = '0;

    unique case (kind)
      KIND_GESTURE: begin
        window_counter_next  = load_count(overwrite_ticks);
        pending_gesture_next = map_code(gesture_code);
      end
      KIND_TICK: begin
        // Count down every active counter
        servo_x = (servo_counter == TICK_WIDTH'(1));
        idle_x  = (idle_counter == TICK_WIDTH'(1));
        win_x   = (window_counter == TICK_WIDTH'(1));
        delay_x = (delay_counter == TICK_WIDTH'(1));
        if (servo_counter != '0) servo_counter_next = servo_counter - TICK_WIDTH'(1);
        if (idle_counter != '0) idle_counter_next = idle_counter - TICK_WIDTH'(1);
        if (window_counter != '0) window_counter_next = window_counter - TICK_WIDTH'(1);
        if (delay_counter != '0) delay_counter_next = delay_counter - TICK_WIDTH'(1);

        if (servo_x) drive_mode_next = DRIVE_OFF;

        // Idle timeout drops the collected table
        if (idle_x) begin
          for (int i = 0; i < SEQ_LEN; i++) entries_next[i] = '0;
          write_position_next = '0;
        end

        // Commit the pending gesture, clearing a full table first
        if (win_x) begin
          if (32'(write_position_next) >= 32'(SEQ_LEN)) begin
            for (int i = 0; i < SEQ_LEN; i++) entries_next[i] = '0;
            write_position_next = '0;
          end
          for (int i = 0; i < SEQ_LEN; i++) begin
            if (write_position_next == POS_W'(i)) entries_next[i] = pending_gesture;
          end
          write_position_next  = write_position_next + POS_W'(1);
          pending_gesture_next = '0;
          idle_counter_next    = load_count(idle_reset_ticks);
        end

        // Carry out a due toggle
        if (delay_x) begin
          for (int i = 0; i < SEQ_LEN; i++) entries_next[i] = '0;
          write_position_next = '0;
          scheduled_flag_next = 1'b0;
          drive_mode_next     = lock_state_next ? DRIVE_UNLOCK : DRIVE_LOCK;
          servo_counter_next  = load_count(servo_on_ticks);
          lock_state_next     = !lock_state_next;
        end

        // Compare the table with the goal, slot by slot
        table_equal = 1'b1;
        for (int i = 0; i < SEQ_LEN; i++) begin
          goal_code = (i < GOAL_SLOTS) ? map_code(CODE_W'(goal_sequence >> (CODE_W * i)))
                                       : '0;
          if (entries_next[i] != goal_code) table_equal = 1'b0;
        end

        if (table_equal && lock_state_next && !scheduled_flag_next) begin
          delay_counter_next  = load_count(toggle_delay_ticks);
          scheduled_flag_next = 1'b1;
          matched             = 1'b1;
        end
      end
      KIND_REQUEST: begin
        delay_counter_next  = load_count(toggle_delay_ticks);
        scheduled_flag_next = 1'b1;
      end
      default: ;
    endcase
  end

  // Advance the state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SEQ_LEN; i++) entries[i] <= '0;
      write_position  <= '0;
      pending_gesture <= '0;
      window_counter  <= '0;
      idle_counter    <= '0;
      delay_counter   <= '0;
      servo_counter   <= '0;
      lock_state      <= 1'b0;
      scheduled_flag  <= 1'b0;
      drive_mode      <= DRIVE_OFF;
    end else if (step) begin
      entries         <= entries_next;
      write_position  <= write_position_next;
      pending_gesture <= pending_gesture_next;
      window_counter  <= window_counter_next;
      idle_counter    <= idle_counter_next;
      delay_counter   <= delay_counter_next;
      servo_counter   <= servo_counter_next;
      lock_state      <= lock_state_next;
      scheduled_flag  <= scheduled_flag_next;
      drive_mode      <= drive_mode_next;
    end
  end

  // Report the state after the step
  always_comb begin
    result.locked          = lock_state_next;
    result.servo_drive     = drive_mode_next;
    result.toggle_pending  = scheduled_flag_next;
    result.collected_count = COUNT_W'(write_position_next);
    result.match_now       = matched;
  end

  // The table never holds more than its length
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    32'(write_position) <= 32'(SEQ_LEN))
    else $error("write position beyond table length");

  // A scheduled toggle always has its delay running
  a_sched_delay: assert property (@(posedge clk) disable iff (rst)
    scheduled_flag == (delay_counter != '0))
    else $error("toggle flag and delay counter disagree");

  // The servo is driven exactly while its counter runs
  a_servo_drive: assert property (@(posedge clk) disable iff (rst)
    (drive_mode != DRIVE_OFF) == (servo_counter != '0))
    else $error("servo drive and servo counter disagree");

  // A match schedules a toggle on a locked lock
  a_match_state: assert property (@(posedge clk) disable iff (rst)
    step && result.match_now |=> lock_state && scheduled_flag)
    else $error("match without locked state and scheduled toggle");

endmodule

`default_nettype wire

FILE: hw/rtl/gsl_out_buf.sv
// Two-entry result buffer: output register plus skid stage.
// Depends on gsl_pkg and gsl_out_if.
`default_nettype none

module gsl_out_buf import gsl_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire gsl_result_t  push_data,
  output logic              can_push,
  gsl_out_if.source         result_out
);

  logic        main_valid;
  logic        skid_valid;
  gsl_result_t main_data;
  gsl_result_t skid_data;
  logic        main_free;

  assign main_free = !main_valid || result_out.ready;
  assign can_push  = !skid_valid;

  // Track which stages hold a word
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      main_valid <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Move payload: skid drains first, otherwise a new word lands where there is room
  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid) main_data <= skid_data;
      else if (push) main_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assign result_out.valid           = main_valid;
  assign result_out.locked          = main_data.locked;
  assign result_out.servo_drive     = main_data.servo_drive;
  assign result_out.toggle_pending  = main_data.toggle_pending;
  assign result_out.collected_count = main_data.collected_count;
  assign result_out.match_now       = main_data.match_now;

endmodule

`default_nettype wire
